// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ----- rtl/stt_pkg.sv -----
// shared types and codes of the sorted time table
`default_nettype none
package stt_pkg;
  localparam int KEY_W = 64;
  localparam int REC_W = 27;
  localparam int ENTRY_W = KEY_W + REC_W;
  localparam logic [10:0] MIN_PER_HOUR = 11'd60;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_LIST_ALL = 3'd1;
  localparam logic [2:0] CMD_LIST_HOUR = 3'd2;
  localparam logic [2:0] CMD_DEL_KEY = 3'd3;
  localparam logic [2:0] CMD_DEL_HOUR = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_DUP = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN
  } state_t;

  function automatic logic [10:0] rec_time(input logic [REC_W-1:0] r);
    rec_time = 11'(r[4:0]) * MIN_PER_HOUR + 11'(r[10:5]);
  endfunction
endpackage
`default_nettype wire

// ----- rtl/sorted_time_table.sv -----
// top level of the sorted time table: sequencer around one entry ram
//
// channel   signals                      handshake
// command   cmd key hour minute ...      start & !busy
// result    status slot out_* removed    valid, one cycle, last marks end
//
// one read pass over the stored entries, one entry per ram read cycle
// insert adds a second pass that moves entries up from the insert point
// delete key adds a pass that moves entries down over the removed one
// full table on insert and empty table on other commands answer in the cycle after start
// rst clears count and sequencer, ram contents need no clearing
// results cannot be held off, each is registered onto the outputs as it is formed
`default_nettype none
module sorted_time_table #(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  cmd,
  input  wire logic [63:0] key,
  input  wire logic [4:0]  hour,
  input  wire logic [5:0]  minute,
  input  wire logic        late,
  input  wire logic [3:0]  gate,
  input  wire logic [4:0]  new_hour,
  input  wire logic [5:0]  new_minute,
  output logic             valid,
  output logic [2:0]       status,
  output logic [3:0]       slot,
  output logic [63:0]      out_key,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute,
  output logic             out_late,
  output logic [3:0]       out_gate,
  output logic [4:0]       out_new_hour,
  output logic [5:0]       out_new_minute,
  output logic [4:0]       removed,
  output logic             last
);
  import stt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  state_t st, st_next;

  logic [CW-1:0]    cnt, ptr, idx_q, pos, nmatch, wptr;
  logic             vld_q, found, pos_found, held_v;
  logic [2:0]       cmd_q;
  logic [4:0]       hour_q;
  logic [KEY_W-1:0] key_q, held_key;
  logic [REC_W-1:0] rec_q, held_rec;
  logic [CW-1:0]    held_idx;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [REC_W-1:0]   rd_rec, new_rec;

  logic             issue, pass_end, hmatch, lmatch;
  logic             em_v, em_last, em_has;
  logic [2:0]       em_status;
  logic [CW-1:0]    em_slot, em_removed;
  logic [KEY_W-1:0] em_key;
  logic [REC_W-1:0] em_rec;

  stt_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign rd_key = rdata[ENTRY_W-1:REC_W];
  assign rd_rec = rdata[REC_W-1:0];
  assign hmatch = rd_rec[4:0] == hour_q;
  assign lmatch = (cmd_q == CMD_LIST_ALL) || hmatch;
  assign new_rec = late ? {new_minute, new_hour, 4'd0, 1'b1, minute, hour}
                        : {6'd0, 5'd0, gate, 1'b0, minute, hour};
  assign busy = st != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    issue = 1'b0;
    pass_end = 1'b0;
    raddr = ptr[AW-1:0];
    we = 1'b0;
    waddr = idx_q[AW-1:0];
    wdata = rdata;
    em_v = 1'b0;
    em_last = 1'b1;
    em_has = 1'b0;
    em_status = ST_OK;
    em_slot = '0;
    em_removed = '0;
    em_key = held_key;
    em_rec = held_rec;
    case (st)
      S_IDLE: begin
        if (start && cmd <= CMD_DEL_HOUR) begin
          if (cmd == CMD_INSERT && cnt == FULL_CNT) begin
            em_v = 1'b1;
            em_status = ST_FULL;
          end else if (cmd != CMD_INSERT && cnt == '0) begin
            em_v = 1'b1;
            em_status = ST_EMPTY;
          end else begin
            st_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        issue = ptr < cnt;
        pass_end = !issue && !vld_q;
        if (vld_q && cmd_q == CMD_DEL_HOUR && !hmatch) begin
          we = 1'b1;
          waddr = wptr[AW-1:0];
        end
        if (vld_q && (cmd_q == CMD_LIST_ALL || cmd_q == CMD_LIST_HOUR) && lmatch && held_v) begin
          em_v = 1'b1;
          em_last = 1'b0;
          em_has = 1'b1;
          em_slot = held_idx;
        end
        if (pass_end) begin
          st_next = S_IDLE;
          em_v = 1'b1;
          case (cmd_q)
            CMD_INSERT: begin
              if (found) begin
                em_status = ST_DUP;
              end else begin
                em_v = 1'b0;
                st_next = S_SHIFT_UP;
              end
            end
            CMD_LIST_ALL, CMD_LIST_HOUR: begin
              if (held_v) begin
                em_has = 1'b1;
                em_slot = held_idx;
              end else begin
                em_status = ST_NOT_FOUND;
              end
            end
            CMD_DEL_KEY: begin
              if (found) begin
                em_has = 1'b1;
                em_slot = pos;
                em_removed = CW'(1);
                st_next = S_SHIFT_DN;
              end else begin
                em_status = ST_NOT_FOUND;
              end
            end
            default: begin
              if (nmatch != '0) begin
                em_slot = pos;
                em_removed = nmatch;
              end else begin
                em_status = ST_NOT_FOUND;
              end
            end
          endcase
        end
      end
      S_SHIFT_UP: begin
        issue = ptr > pos;
        raddr = AW'(ptr - CW'(1));
        we = vld_q;
        pass_end = !issue && !vld_q;
        if (pass_end) begin
          we = 1'b1;
          waddr = pos[AW-1:0];
          wdata = {key_q, rec_q};
          em_v = 1'b1;
          em_has = 1'b1;
          em_slot = pos;
          em_key = key_q;
          em_rec = rec_q;
          st_next = S_IDLE;
        end
      end
      S_SHIFT_DN: begin
        issue = ptr < cnt;
        we = vld_q;
        pass_end = !issue && !vld_q;
        if (pass_end) begin
          st_next = S_IDLE;
        end
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      vld_q <= 1'b0;
      valid <= 1'b0;
    end else begin
      valid <= em_v;
      vld_q <= issue;
      if (issue) begin
        idx_q <= (st == S_SHIFT_DN) ? ptr - CW'(1) : ptr;
        ptr <= (st == S_SHIFT_UP) ? ptr - CW'(1) : ptr + CW'(1);
      end
      case (st)
        S_IDLE: begin
          cmd_q <= cmd;
          hour_q <= hour;
          key_q <= key;
          rec_q <= new_rec;
          ptr <= '0;
          pos <= cnt;
          found <= 1'b0;
          pos_found <= 1'b0;
          held_v <= 1'b0;
          nmatch <= '0;
          wptr <= '0;
        end
        S_SCAN: begin
          if (vld_q) begin
            case (cmd_q)
              CMD_INSERT: begin
                if (rd_key == key_q) begin
                  found <= 1'b1;
                end
                if (!pos_found && rec_time(rec_q) < rec_time(rd_rec)) begin
                  pos <= idx_q;
                  pos_found <= 1'b1;
                end
              end
              CMD_LIST_ALL, CMD_LIST_HOUR: begin
                if (lmatch) begin
                  held_v <= 1'b1;
                  held_idx <= idx_q;
                  held_key <= rd_key;
                  held_rec <= rd_rec;
                end
              end
              CMD_DEL_KEY: begin
                if (!found && rd_key == key_q) begin
                  found <= 1'b1;
                  pos <= idx_q;
                  held_key <= rd_key;
                  held_rec <= rd_rec;
                end
              end
              default: begin
                if (hmatch) begin
                  if (nmatch == '0) begin
                    pos <= idx_q;
                  end
                  nmatch <= nmatch + CW'(1);
                end else begin
                  wptr <= wptr + CW'(1);
                end
              end
            endcase
          end
          if (pass_end) begin
            if (cmd_q == CMD_INSERT) begin
              ptr <= cnt;
            end else if (cmd_q == CMD_DEL_KEY) begin
              ptr <= pos + CW'(1);
            end else if (cmd_q == CMD_DEL_HOUR) begin
              cnt <= cnt - nmatch;
            end
          end
        end
        S_SHIFT_UP: begin
          if (pass_end) begin
            cnt <= cnt + CW'(1);
          end
        end
        S_SHIFT_DN: begin
          if (pass_end) begin
            cnt <= cnt - CW'(1);
          end
        end
        default: begin
          ptr <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    status <= em_status;
    slot <= 4'(em_slot);
    out_key <= em_has ? em_key : '0;
    out_hour <= em_has ? em_rec[4:0] : '0;
    out_minute <= em_has ? em_rec[10:5] : '0;
    out_late <= em_has ? em_rec[11] : 1'b0;
    out_gate <= em_has ? em_rec[15:12] : '0;
    out_new_hour <= em_has ? em_rec[20:16] : '0;
    out_new_minute <= em_has ? em_rec[26:21] : '0;
    removed <= 5'(em_removed);
    last <= em_last;
  end
endmodule
`default_nettype wire

// ----- rtl/stt_ram.sv -----
// generic single-port-write ram with registered read
`default_nettype none
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/stt_checker.sv -----
// port-level checker for the sorted time table and its bind
`default_nettype none
`include "assert_macros.svh"
module stt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [2:0] cmd,
  input wire logic       valid,
  input wire logic [2:0] status,
  input wire logic [3:0] slot,
  input wire logic [4:0] removed,
  input wire logic       last
);
  import stt_pkg::*;

  `ASSERT_NXT(a_cmd_answers, clk, rst, start && !busy && cmd <= CMD_DEL_HOUR, busy || valid)
  `ASSERT_IMP(a_error_is_last, clk, rst, valid && status != ST_OK, last)
  `ASSERT_IMP(a_more_follows, clk, rst, valid && !last, busy)
  `ASSERT_IMP(a_full_clean, clk, rst, valid && status == ST_FULL, slot == 4'd0 && removed == 5'd0)
endmodule

bind sorted_time_table stt_checker u_stt_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .valid(valid),
  .status(status), .slot(slot), .removed(removed), .last(last)
);
`default_nettype wire
